@@ rtl/core/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MAX_TASKS     = 8;
  localparam int DEF_NUM_TASKS = 8;
  localparam int TASK_W        = 3;
  localparam int PRIO_W        = 8;
  localparam int TIME_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int CFG_W         = MAX_TASKS * PRIO_W;
  localparam int MARK_W        = 3;

  // task mark bit positions
  localparam int MARK_TIMEOUT = 0;
  localparam int MARK_BLOCKED = 1;
  localparam int MARK_WAITING = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHEDULE = 3'd0,
    CMD_DELAY    = 3'd1,
    CMD_WAIT     = 3'd2,
    CMD_WAKE     = 3'd3,
    CMD_QUERY    = 3'd4
  } pts_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 2'd0,
    STS_NO_RUNNABLE = 2'd1,
    STS_NO_CURRENT  = 2'd2
  } pts_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } pts_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input item
    logic upd;     // delay / wait update of the current task
    logic wake;    // clear the target task
    logic issue;   // read the next task entry into the eval stage
    logic finish;  // result taken into the output register
  } pts_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cur_valid;
    logic             last_issue;
  } pts_sts_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   chosen_task;
    logic                switched;
    logic                resumed_by_timeout;
    logic [TIME_W-1:0]   wait_left;
  } pts_res_t;

endpackage

@@ rtl/core/pts_ctrl.sv @@
// ----------------------------------------------------------------------------
// pts_ctrl
// Command sequencer: dispatch, task update, entry scan and result hand-off.
// ----------------------------------------------------------------------------
module pts_ctrl
  import pts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_free,
  input  pts_sts_t sts,
  output pts_ctl_t ctl
);

  pts_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (sts.cmd inside {CMD_SCHEDULE, CMD_QUERY}) begin
          state_nxt = ST_SCAN;
        end else if (sts.cmd inside {CMD_DELAY, CMD_WAIT}) begin
          state_nxt = sts.cur_valid ? ST_UPDATE : ST_FINISH;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_UPDATE: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    ctl.load   = in_valid && (state_r == ST_IDLE);
    ctl.upd    = (state_r == ST_UPDATE);
    ctl.wake   = (state_r == ST_DISPATCH) && (sts.cmd == CMD_WAKE);
    ctl.issue  = (state_r == ST_SCAN);
    ctl.finish = (state_r == ST_FINISH) && out_free;
  end

endmodule

@@ rtl/core/pts_dp.sv @@
// ----------------------------------------------------------------------------
// pts_dp
// Task table, priority register and the two-stage entry scan.
// ----------------------------------------------------------------------------
module pts_dp
  import pts_pkg::*;
#(
  parameter int NUM_TASKS = DEF_NUM_TASKS
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic [TIME_W-1:0]   in_delay_ms,
  input  logic                in_forever_req,
  input  logic [TASK_W-1:0]   in_target_task,
  input  pts_ctl_t            ctl,
  output pts_sts_t            sts,
  output pts_res_t            res
);

  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  logic [CFG_W-1:0]  prio_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] len_r;
  logic              forever_r;
  logic [TASK_W-1:0] target_r;

  logic [MARK_W-1:0] marks_r [NUM_TASKS];
  logic [TIME_W-1:0] start_r [NUM_TASKS];
  logic [TIME_W-1:0] wlen_r  [NUM_TASKS];
  logic [TW-1:0]     cur_idx_r;
  logic              cur_valid_r;

  logic [TW-1:0]     cnt_r;

  // eval stage
  logic              p_vld_r;
  logic [TW-1:0]     p_idx_r;
  logic [MARK_W-1:0] p_marks_r;
  logic [TIME_W-1:0] p_len_r;
  logic [TIME_W-1:0] p_gone_r;
  logic [PRIO_W-1:0] p_prio_r;

  // accumulators
  logic              found_r;
  logic [TW-1:0]     best_r;
  logic [PRIO_W-1:0] best_prio_r;
  logic              best_to_r;
  logic              zero_hit_r;
  logic [TIME_W-1:0] least_r;

  logic              is_query;
  logic              e_wait, e_blk, e_expired, e_cand, e_cand_to, e_take;
  logic [TIME_W:0]   q_diff;
  logic              q_expired;
  logic              wake_ok;

  assign is_query = (cmd_r == CMD_QUERY);
  assign wake_ok  = ({1'b0, target_r} < (TASK_W + 1)'(NUM_TASKS));

  always_comb begin
    e_wait    = p_marks_r[MARK_WAITING];
    e_blk     = p_marks_r[MARK_BLOCKED];
    e_expired = p_gone_r > p_len_r;
    e_cand    = !e_blk && (!e_wait || e_expired);
    e_cand_to = e_wait ? 1'b1 : p_marks_r[MARK_TIMEOUT];
    e_take    = e_cand && (!found_r || (p_prio_r < best_prio_r));
    q_diff    = {1'b0, p_len_r} - {1'b0, p_gone_r};
    q_expired = q_diff[TIME_W] || (q_diff[TIME_W-1:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= '0;
    end else if (cfg_wr_en) begin
      prio_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r     <= in_cmd;
      now_r     <= in_now_ms;
      len_r     <= in_delay_ms;
      forever_r <= in_forever_req;
      target_r  <= in_target_task;
    end
  end

  // marks: update, wake and expiry never fall in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) marks_r[i] <= '0;
    end else if (ctl.upd) begin
      if (cmd_r == CMD_WAIT && forever_r) begin
        marks_r[cur_idx_r][MARK_BLOCKED] <= 1'b1;
      end else begin
        marks_r[cur_idx_r][MARK_TIMEOUT] <= 1'b0;
        marks_r[cur_idx_r][MARK_WAITING] <= 1'b1;
      end
    end else if (ctl.wake && wake_ok) begin
      marks_r[target_r[TW-1:0]] <= '0;
    end else if (p_vld_r && !is_query && !e_blk && e_wait && e_expired) begin
      marks_r[p_idx_r][MARK_WAITING] <= 1'b0;
      marks_r[p_idx_r][MARK_TIMEOUT] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd && !(cmd_r == CMD_WAIT && forever_r)) begin
      start_r[cur_idx_r] <= now_r;
      wlen_r[cur_idx_r]  <= len_r;
    end else if (ctl.wake && wake_ok) begin
      start_r[target_r[TW-1:0]] <= '0;
      wlen_r[target_r[TW-1:0]]  <= '0;
    end else if (p_vld_r && !is_query && !e_blk && e_wait && e_expired) begin
      start_r[p_idx_r] <= '0;
      wlen_r[p_idx_r]  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_idx_r   <= '0;
      cur_valid_r <= 1'b0;
    end else if (ctl.finish && found_r) begin
      cur_idx_r   <= best_r;
      cur_valid_r <= 1'b1;
    end
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      p_vld_r <= ctl.issue;
      if (ctl.load) begin
        cnt_r <= '0;
      end else if (ctl.issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      p_idx_r   <= cnt_r;
      p_marks_r <= marks_r[cnt_r];
      p_len_r   <= wlen_r[cnt_r];
      p_gone_r  <= now_r - start_r[cnt_r];
      p_prio_r  <= prio_r[cnt_r * PRIO_W +: PRIO_W];
    end
  end

  // eval stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      zero_hit_r <= 1'b0;
      least_r    <= '1;
    end else if (ctl.load) begin
      found_r    <= 1'b0;
      zero_hit_r <= 1'b0;
      least_r    <= '1;
    end else if (p_vld_r) begin
      if (is_query) begin
        if (e_wait) begin
          if (q_expired) begin
            zero_hit_r <= 1'b1;
          end else if (q_diff[TIME_W-1:0] < least_r) begin
            least_r <= q_diff[TIME_W-1:0];
          end
        end
      end else if (e_take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_vld_r && !is_query && e_take) begin
      best_r      <= p_idx_r;
      best_prio_r <= p_prio_r;
      best_to_r   <= e_cand_to;
    end
  end

  always_comb begin
    sts.cmd        = cmd_r;
    sts.cur_valid  = cur_valid_r;
    sts.last_issue = (cnt_r == TW'(NUM_TASKS - 1));
  end

  always_comb begin
    res = '0;
    case (cmd_r)
      CMD_SCHEDULE, CMD_DELAY, CMD_WAIT: begin
        if ((cmd_r != CMD_SCHEDULE) && !cur_valid_r) begin
          res.status = STS_NO_CURRENT;
        end else if (found_r) begin
          res.status             = STS_OK;
          res.chosen_task        = TASK_W'(best_r);
          res.switched           = 1'b1;
          res.resumed_by_timeout = best_to_r;
        end else begin
          res.status = STS_NO_RUNNABLE;
        end
      end
      CMD_QUERY: res.wait_left = zero_hit_r ? '0 : least_r;
      default:   res = '0;
    endcase
  end

endmodule

@@ rtl/core/priority_task_scheduler_with_timeouts.sv @@
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_timeouts
// Fixed-priority task selector with timed waits, one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command item. Each item
//   produces exactly one result item on the out_valid/out_ready channel.
//   cfg_wr_en/cfg_wr_data load the 64-bit packed priority word; write it only
//   while no command is in flight.
// Timing:
//   An item is taken only in the idle state. Schedule and query items scan
//   the task table once, one entry per cycle through a two-stage read/eval
//   path; delay and wait first update the current task and then scan the
//   table as well. Wake, rejected delay/wait and unknown commands go
//   straight to the result. in_ready is back in the cycle where out_valid
//   rises, so a new item is taken only once the last result is registered.
// Reset:
//   rst_n (sync, active low) clears all task marks, the priority word and
//   the current-task valid flag; no task is current afterwards.
// Stall:
//   The result sits in an output register. While it is full and out_ready is
//   low the sequencer waits in its final state, but idle it takes new items.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_timeouts
  import pts_pkg::*;
#(
  parameter int NUM_TASKS = DEF_NUM_TASKS
)
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  // command items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic [TIME_W-1:0]   in_delay_ms,
  input  logic                in_forever_req,
  input  logic [TASK_W-1:0]   in_target_task,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [TASK_W-1:0]   out_chosen_task,
  output logic                out_switched,
  output logic                out_resumed_by_timeout,
  output logic [TIME_W-1:0]   out_wait_left
);

  pts_ctl_t ctl;
  pts_sts_t sts;
  pts_res_t res;
  pts_res_t out_r;
  logic     out_valid_r;
  logic     out_free;

  // output register can take a result when empty or being drained
  assign out_free = !out_valid_r || out_ready;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .ctl      (ctl)
  );

  pts_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_cmd         (in_cmd),
    .in_now_ms      (in_now_ms),
    .in_delay_ms    (in_delay_ms),
    .in_forever_req (in_forever_req),
    .in_target_task (in_target_task),
    .ctl            (ctl),
    .sts            (sts),
    .res            (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_r.status;
  assign out_chosen_task        = out_r.chosen_task;
  assign out_switched           = out_r.switched;
  assign out_resumed_by_timeout = out_r.resumed_by_timeout;
  assign out_wait_left          = out_r.wait_left;

  // an accepted item keeps the input side closed on the next cycle
  a_one_in_flight: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("new item taken while one is in flight");

  // no chosen task or timeout flag without a switch
  a_no_switch_fields: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_switched) |-> (out_chosen_task == '0 && !out_resumed_by_timeout)
  ) else $error("chosen fields set without a switch");

  // a sleep time only comes from a query, which never switches
  a_sleep_only_query: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_wait_left != '0) |-> (!out_switched && out_status == STS_OK)
  ) else $error("sleep time on a scheduling result");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_wait_left))
  ) else $error("pending result overwritten");

endmodule
